// ===== src/tbd_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and helpers for the twisted box distance pipeline.
package tbd_pkg;

   localparam int unsigned FRAC_BITS_DEFAULT = 16;

   localparam logic [31:0] TURN_K  = 32'd2050695827;
   localparam logic [30:0] HALF_PI = 31'd1686629713;
   localparam logic [30:0] Q30_ONE = 31'd1073741824;
   localparam logic [31:0] OUT_MAX = 32'h7FFF_FFFF;

   localparam int unsigned NUM_TERMS  = 5;
   localparam int unsigned CELL_LAT   = 3;
   localparam int unsigned SQRT_STEPS = 32;

   localparam int unsigned CSR_ADDR_W    = 3;
   localparam logic        REG_HALF_EDGE = 1'b0;

   // divisor of each series term, innermost first
   function automatic int unsigned term_divisor(input int unsigned idx);
      int unsigned d;
      case (idx)
         0: d = 110;
         1: d = 72;
         2: d = 42;
         3: d = 20;
         default: d = 6;
      endcase
      return d;
   endfunction

endpackage

// ===== src/tbd_horner_cell.sv =====
`timescale 1ns / 1ps
// One series term of the quarter sine: t_out = 1 - ((x2 * t_in) >> 30) / DIVISOR.
module tbd_horner_cell #(
   parameter int unsigned DIVISOR = 6
) (
   input  logic        clock,
   input  logic [31:0] in_x2,
   input  logic [30:0] in_t,
   output logic [31:0] out_x2,
   output logic [30:0] out_t
);

   localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DIVISOR);

   logic [63:0] prod_ff, prod_in;
   logic [31:0] x2a_ff, x2b_ff, x2c_ff;
   logic [31:0] num_ff, num_in;
   logic [63:0] scaled_ff, scaled_in;
   logic [30:0] t_ff, t_in;
   logic [31:0] quo0;
   logic [39:0] back;
   logic [39:0] rem;
   logic [32:0] quo;
   logic [32:0] diff;

   always_comb begin
      prod_in   = 64'(in_x2) * 64'(in_t);
      num_in    = prod_ff[61:30];
      scaled_in = 64'(num_in) * 64'(RECIP);
      quo0      = scaled_ff[63:32];
      back      = 40'(quo0) * 40'(DIVISOR);
      rem       = 40'(num_ff) - back;
      quo       = 33'(quo0) + ((rem >= 40'(DIVISOR)) ? 33'd1 : 33'd0);
      diff      = 33'(tbd_pkg::Q30_ONE) - quo;
      t_in      = diff[30:0];
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      x2a_ff    <= in_x2;
      num_ff    <= num_in;
      scaled_ff <= scaled_in;
      x2b_ff    <= x2a_ff;
      t_ff      <= t_in;
      x2c_ff    <= x2b_ff;
   end

   assign out_x2 = x2c_ff;
   assign out_t  = t_ff;

endmodule

// ===== src/tbd_sqrt_cell.sv =====
`timescale 1ns / 1ps
// One bit step of the integer square root.
module tbd_sqrt_cell #(
   parameter int unsigned STEP = 0
) (
   input  logic        clock,
   input  logic [63:0] in_rem,
   input  logic [63:0] in_root,
   output logic [63:0] out_rem,
   output logic [63:0] out_root
);

   localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

   logic [63:0] rem_ff, rem_in;
   logic [63:0] root_ff, root_in;
   logic [63:0] trial;

   always_comb begin
      trial = in_root + BIT;
      if (in_rem >= trial) begin
         rem_in  = in_rem - trial;
         root_in = (in_root >> 1) + BIT;
      end else begin
         rem_in  = in_rem;
         root_in = in_root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign out_rem  = rem_ff;
   assign out_root = root_ff;

endmodule

// ===== src/twisted_box_distance.sv =====
`timescale 1ns / 1ps
// Top level: twisted box signed distance, fully pipelined.
//
// Usage: drive req_pos_x/y/z with start high; a request is taken at every
// clock edge where start is high and busy is low. busy is always low, so a
// new point may be issued every cycle (one point per cycle sustained).
// Each result appears on rsp_distance for exactly one cycle with rsp_valid
// high, in request order. It passes through the pipeline registers: 4
// phase/sine setup stages, five series cells of 3 stages each, 7 twist/box
// stages, 32 square root cells, one output stage.
// The receiver cannot stall; results must be taken as they appear.
// half_edge is at APB byte address 0; reads return it. The user must write
// it only while no request is in flight; the block does not enforce this.
// Reset (synchronous) clears all in-flight requests and sets half_edge to 1.0.
module twisted_box_distance #(
   parameter int unsigned FRAC_BITS = tbd_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic signed [31:0]              req_pos_x,
   input  logic signed [31:0]              req_pos_y,
   input  logic signed [31:0]              req_pos_z,
   output logic                            rsp_valid,
   output logic signed [31:0]              rsp_distance,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tbd_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);

   localparam int unsigned HORNER_LAT = tbd_pkg::NUM_TERMS * tbd_pkg::CELL_LAT;
   localparam int unsigned LAT = 4 + HORNER_LAT + 7 + tbd_pkg::SQRT_STEPS + 1;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] z;
      logic [1:0]         quad;
      logic [31:0]        ay;
      logic [30:0]        xa;
      logic [30:0]        xb;
   } side_type;

   typedef struct packed {
      logic               huge;
      logic signed [33:0] dmax;
   } tail_type;

   // configuration
   logic [30:0] half_edge_ff, half_edge_in;
   logic        csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      half_edge_in = half_edge_ff;
      if (csr_write && paddr[2] == tbd_pkg::REG_HALF_EDGE) begin
         half_edge_in = pwdata[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_edge_ff <= 31'(1) << FRAC_BITS;
      end else begin
         half_edge_ff <= half_edge_in;
      end
   end

   assign prdata = (paddr[2] == tbd_pkg::REG_HALF_EDGE) ? {1'b0, half_edge_ff} : 32'd0;

   // valid chain
   logic           accept;
   logic [LAT-1:0] vld_ff, vld_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign vld_in = {vld_ff[LAT-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // stage 1: capture
   logic signed [31:0] s1_x_ff, s1_y_ff, s1_z_ff;

   // stage 2: phase product
   logic signed [63:0] s2_prod_ff, s2_prod_in;
   logic signed [63:0] s2_ye, s2_ke;
   logic signed [31:0] s2_x_ff, s2_z_ff;
   logic [31:0]        s2_ay_ff, s2_ay_in;

   // stage 3: angle scaling
   logic [31:0]        s3_u;
   logic [30:0]        s3_ra, s3_rb;
   logic [61:0]        s3_pa_ff, s3_pa_in, s3_pb_ff, s3_pb_in;
   logic [1:0]         s3_quad_ff;
   logic signed [31:0] s3_x_ff, s3_z_ff;
   logic [31:0]        s3_ay_ff;

   // stage 4: square of angle
   logic [30:0]        s4_xa, s4_xb;
   logic [61:0]        s4_sqa_ff, s4_sqb_ff;
   side_type           s4_side_ff, s4_side_in;

   always_comb begin
      s2_ye      = 64'(s1_y_ff);
      s2_ke      = 64'(tbd_pkg::TURN_K);
      s2_prod_in = s2_ye * s2_ke;
      s2_ay_in   = s1_y_ff[31] ? 32'(-33'(s1_y_ff)) : 32'(s1_y_ff);
      s3_u       = s2_prod_ff[FRAC_BITS+31:FRAC_BITS];
      s3_ra      = {1'b0, s3_u[29:0]};
      s3_rb      = tbd_pkg::Q30_ONE - s3_ra;
      s3_pa_in   = 62'(s3_ra) * 62'(tbd_pkg::HALF_PI);
      s3_pb_in   = 62'(s3_rb) * 62'(tbd_pkg::HALF_PI);
      s4_xa      = s3_pa_ff[60:30];
      s4_xb      = s3_pb_ff[60:30];
      s4_side_in = '{x: s3_x_ff, z: s3_z_ff, quad: s3_quad_ff, ay: s3_ay_ff,
                     xa: s4_xa, xb: s4_xb};
   end

   always_ff @(posedge clock) begin
      s1_x_ff    <= req_pos_x;
      s1_y_ff    <= req_pos_y;
      s1_z_ff    <= req_pos_z;
      s2_prod_ff <= s2_prod_in;
      s2_x_ff    <= s1_x_ff;
      s2_z_ff    <= s1_z_ff;
      s2_ay_ff   <= s2_ay_in;
      s3_pa_ff   <= s3_pa_in;
      s3_pb_ff   <= s3_pb_in;
      s3_quad_ff <= s3_u[31:30];
      s3_x_ff    <= s2_x_ff;
      s3_z_ff    <= s2_z_ff;
      s3_ay_ff   <= s2_ay_ff;
      s4_sqa_ff  <= 62'(s4_xa) * 62'(s4_xa);
      s4_sqb_ff  <= 62'(s4_xb) * 62'(s4_xb);
      s4_side_ff <= s4_side_in;
   end

   // series cells, one chain per quarter sine
   logic [31:0] ha_x2 [0:tbd_pkg::NUM_TERMS];
   logic [30:0] ha_t  [0:tbd_pkg::NUM_TERMS];
   logic [31:0] hb_x2 [0:tbd_pkg::NUM_TERMS];
   logic [30:0] hb_t  [0:tbd_pkg::NUM_TERMS];

   assign ha_x2[0] = s4_sqa_ff[61:30];
   assign hb_x2[0] = s4_sqb_ff[61:30];
   assign ha_t[0]  = tbd_pkg::Q30_ONE;
   assign hb_t[0]  = tbd_pkg::Q30_ONE;

   for (genvar g = 0; g < tbd_pkg::NUM_TERMS; g++) begin : g_term
      tbd_horner_cell #(.DIVISOR(tbd_pkg::term_divisor(g))) u_cell_a (
         .clock  (clock),
         .in_x2  (ha_x2[g]),
         .in_t   (ha_t[g]),
         .out_x2 (ha_x2[g+1]),
         .out_t  (ha_t[g+1])
      );
      tbd_horner_cell #(.DIVISOR(tbd_pkg::term_divisor(g))) u_cell_b (
         .clock  (clock),
         .in_x2  (hb_x2[g]),
         .in_t   (hb_t[g]),
         .out_x2 (hb_x2[g+1]),
         .out_t  (hb_t[g+1])
      );
   end

   side_type side_ff [0:HORNER_LAT-1];

   always_ff @(posedge clock) begin
      side_ff[0] <= s4_side_ff;
      for (int k = 1; k < HORNER_LAT; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
   end

   side_type h_side;
   assign h_side = side_ff[HORNER_LAT-1];

   // stage 20: sine values
   logic [61:0]        s20_pa, s20_pb;
   logic [30:0]        s20_sa_ff, s20_sb_ff;
   logic [1:0]         s20_quad_ff;
   logic signed [31:0] s20_x_ff, s20_z_ff;
   logic [31:0]        s20_ay_ff;

   always_comb begin
      s20_pa = 62'(h_side.xa) * 62'(ha_t[tbd_pkg::NUM_TERMS]);
      s20_pb = 62'(h_side.xb) * 62'(hb_t[tbd_pkg::NUM_TERMS]);
   end

   always_ff @(posedge clock) begin
      s20_sa_ff   <= s20_pa[60:30];
      s20_sb_ff   <= s20_pb[60:30];
      s20_quad_ff <= h_side.quad;
      s20_x_ff    <= h_side.x;
      s20_z_ff    <= h_side.z;
      s20_ay_ff   <= h_side.ay;
   end

   // stage 21: quadrant fold and rotation products
   logic signed [63:0] s21_sn, s21_cs, s21_av, s21_bv, s21_xe, s21_ze;
   logic signed [63:0] s21_xc_ff, s21_zs_ff, s21_xs_ff, s21_zc_ff;
   logic [31:0]        s21_ay_ff;

   always_comb begin
      s21_av = 64'(s20_sa_ff);
      s21_bv = 64'(s20_sb_ff);
      s21_xe = 64'(s20_x_ff);
      s21_ze = 64'(s20_z_ff);
      case (s20_quad_ff)
         2'd0: begin
            s21_sn = s21_av;
            s21_cs = s21_bv;
         end
         2'd1: begin
            s21_sn = s21_bv;
            s21_cs = -s21_av;
         end
         2'd2: begin
            s21_sn = -s21_av;
            s21_cs = -s21_bv;
         end
         default: begin
            s21_sn = -s21_bv;
            s21_cs = s21_av;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      s21_xc_ff <= s21_xe * s21_cs;
      s21_zs_ff <= s21_ze * s21_sn;
      s21_xs_ff <= s21_xe * s21_sn;
      s21_zc_ff <= s21_ze * s21_cs;
      s21_ay_ff <= s20_ay_ff;
   end

   // stage 22: rotated coordinates
   logic signed [63:0] s22_e0_ff, s22_e1_ff;
   logic [31:0]        s22_ay_ff;

   always_ff @(posedge clock) begin
      s22_e0_ff <= s21_xc_ff - s21_zs_ff;
      s22_e1_ff <= s21_xs_ff + s21_zc_ff;
      s22_ay_ff <= s21_ay_ff;
   end

   // stage 23: rounded magnitudes
   logic [63:0] s23_a0, s23_a1, s23_r0, s23_r1;
   logic [32:0] s23_m0_ff, s23_m1_ff, s23_m2_ff;

   always_comb begin
      s23_a0 = s22_e0_ff[63] ? 64'(-s22_e0_ff) : 64'(s22_e0_ff);
      s23_a1 = s22_e1_ff[63] ? 64'(-s22_e1_ff) : 64'(s22_e1_ff);
      s23_r0 = s23_a0 + (64'd1 << 29);
      s23_r1 = s23_a1 + (64'd1 << 29);
   end

   always_ff @(posedge clock) begin
      s23_m0_ff <= s23_r0[62:30];
      s23_m1_ff <= s23_r1[62:30];
      s23_m2_ff <= {1'b0, s22_ay_ff};
   end

   // stage 24: distance past each face
   logic signed [33:0] s24_he;
   logic signed [33:0] s24_d0_ff, s24_d1_ff, s24_d2_ff;

   assign s24_he = $signed({3'b000, half_edge_ff});

   always_ff @(posedge clock) begin
      s24_d0_ff <= $signed({1'b0, s23_m0_ff}) - s24_he;
      s24_d1_ff <= $signed({1'b0, s23_m1_ff}) - s24_he;
      s24_d2_ff <= $signed({1'b0, s23_m2_ff}) - s24_he;
   end

   // stage 25: squares, saturation flag, largest component
   function automatic logic is_huge(input logic signed [33:0] d);
      return !d[33] && (d[32] || d[31]);
   endfunction

   function automatic logic [30:0] pos_part(input logic signed [33:0] d);
      return (!d[33] && !d[32] && !d[31]) ? d[30:0] : 31'd0;
   endfunction

   logic [30:0]        s25_p0, s25_p1, s25_p2;
   logic signed [33:0] s25_m01, s25_dmax;
   logic [61:0]        s25_q0_ff, s25_q1_ff, s25_q2_ff;
   tail_type           s25_tail_ff;

   always_comb begin
      s25_p0   = pos_part(s24_d0_ff);
      s25_p1   = pos_part(s24_d1_ff);
      s25_p2   = pos_part(s24_d2_ff);
      s25_m01  = (s24_d1_ff > s24_d0_ff) ? s24_d1_ff : s24_d0_ff;
      s25_dmax = (s24_d2_ff > s25_m01) ? s24_d2_ff : s25_m01;
   end

   always_ff @(posedge clock) begin
      s25_q0_ff        <= 62'(s25_p0) * 62'(s25_p0);
      s25_q1_ff        <= 62'(s25_p1) * 62'(s25_p1);
      s25_q2_ff        <= 62'(s25_p2) * 62'(s25_p2);
      s25_tail_ff.huge <= is_huge(s24_d0_ff) || is_huge(s24_d1_ff) || is_huge(s24_d2_ff);
      s25_tail_ff.dmax <= s25_dmax;
   end

   // stage 26: sum of squares
   logic [63:0] s26_sum_ff;
   tail_type    s26_tail_ff;

   always_ff @(posedge clock) begin
      s26_sum_ff  <= 64'(s25_q0_ff) + 64'(s25_q1_ff) + 64'(s25_q2_ff);
      s26_tail_ff <= s25_tail_ff;
   end

   // square root cells
   logic [63:0] sq_rem  [0:tbd_pkg::SQRT_STEPS];
   logic [63:0] sq_root [0:tbd_pkg::SQRT_STEPS];

   assign sq_rem[0]  = s26_sum_ff;
   assign sq_root[0] = 64'd0;

   for (genvar g = 0; g < tbd_pkg::SQRT_STEPS; g++) begin : g_sqrt
      tbd_sqrt_cell #(.STEP(g)) u_cell (
         .clock    (clock),
         .in_rem   (sq_rem[g]),
         .in_root  (sq_root[g]),
         .out_rem  (sq_rem[g+1]),
         .out_root (sq_root[g+1])
      );
   end

   tail_type tail_ff [0:tbd_pkg::SQRT_STEPS-1];

   always_ff @(posedge clock) begin
      tail_ff[0] <= s26_tail_ff;
      for (int k = 1; k < tbd_pkg::SQRT_STEPS; k++) begin
         tail_ff[k] <= tail_ff[k-1];
      end
   end

   tail_type rt_tail;
   logic [63:0] rt_root;
   logic signed [31:0] dist_ff, dist_in;

   assign rt_tail = tail_ff[tbd_pkg::SQRT_STEPS-1];
   assign rt_root = sq_root[tbd_pkg::SQRT_STEPS];

   always_comb begin
      if (rt_tail.huge) begin
         dist_in = tbd_pkg::OUT_MAX;
      end else if (rt_tail.dmax[33]) begin
         dist_in = rt_tail.dmax[31:0];
      end else if (rt_root > 64'(tbd_pkg::OUT_MAX)) begin
         dist_in = tbd_pkg::OUT_MAX;
      end else begin
         dist_in = rt_root[31:0];
      end
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
   end

   assign rsp_valid    = vld_ff[LAT-1];
   assign rsp_distance = dist_ff;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe after reset");

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result without matching request");

   a_huge_saturates: assert property (@(posedge clock) disable iff (reset)
      vld_ff[LAT-2] && rt_tail.huge |=> rsp_distance == tbd_pkg::OUT_MAX)
      else $error("huge component not saturated");

   a_inside_bounded: assert property (@(posedge clock) disable iff (reset)
      vld_ff[LAT-2] && rt_tail.dmax[33] && !rt_tail.huge |=> rsp_distance[31])
      else $error("inside point gave non-negative distance");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for twisted_box_distance: random and directed points.
module testbench;

   typedef struct packed {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
   } point_type;

   localparam int unsigned DRAIN_CYCLES = 80;
   localparam int unsigned STALL_LIMIT  = 4000;
   localparam int unsigned ADDR_W       = tbd_pkg::CSR_ADDR_W;
   localparam logic [ADDR_W-1:0] ADDR_HALF_EDGE = ADDR_W'(0);
   localparam logic [ADDR_W-1:0] ADDR_UNUSED    = ADDR_W'(4);

   logic clock, reset, start, busy;
   logic signed [31:0] req_pos_x, req_pos_y, req_pos_z;
   logic rsp_valid;
   logic signed [31:0] rsp_distance;
   logic psel, penable, pwrite, pready;
   logic [ADDR_W-1:0] paddr;
   logic [31:0] pwdata, prdata;

   point_type          pending_points[$];
   logic signed [31:0] expected_dist[$];
   logic [30:0]        box_half;
   int unsigned        idle_pct;
   int unsigned        errors;
   int unsigned        quiet_cycles;

   twisted_box_distance dut (.*);

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   function automatic longint unsigned quarter_sine(input longint unsigned a);
      longint unsigned divs[4];
      longint unsigned x, x2, t;
      divs = '{72, 42, 20, 6};
      x  = (a * 64'(tbd_pkg::HALF_PI)) >> 30;
      x2 = (x * x) >> 30;
      t  = 64'(tbd_pkg::Q30_ONE) - x2 / 110;
      for (int i = 0; i < 4; i++)
         t = 64'(tbd_pkg::Q30_ONE) - ((x2 * t) >> 30) / divs[i];
      return (x * t) >> 30;
   endfunction

   function automatic longint unsigned root_floor(input longint unsigned v);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic signed [31:0] box_distance(input point_type p,
                                                        input logic [30:0] half);
      logic [63:0] phase_prod;
      logic [31:0] phase;
      longint unsigned r, sum;
      longint a, b, sn, cs, x, y, z, tx, ty, dmax, res;
      longint unsigned mag[3];
      longint d[3];
      logic huge;
      x = p.px; y = p.py; z = p.pz;
      phase_prod = 64'(y) * 64'(tbd_pkg::TURN_K);
      phase = phase_prod[tbd_pkg::FRAC_BITS_DEFAULT +: 32];
      r = 64'(phase[29:0]);
      a = quarter_sine(r);
      b = quarter_sine(64'(tbd_pkg::Q30_ONE) - r);
      case (phase[31:30])
         2'd0: begin sn = a;  cs = b;  end
         2'd1: begin sn = b;  cs = -a; end
         2'd2: begin sn = -a; cs = -b; end
         default: begin sn = -b; cs = a; end
      endcase
      tx = x * cs - z * sn;
      ty = x * sn + z * cs;
      mag[0] = ((tx < 0) ? -tx : tx) + (64'd1 << 29) >> 30;
      mag[1] = ((ty < 0) ? -ty : ty) + (64'd1 << 29) >> 30;
      mag[2] = (y < 0) ? -y : y;
      sum = 0;
      huge = 1'b0;
      for (int i = 0; i < 3; i++) begin
         d[i] = longint'(mag[i]) - longint'(half);
         if (d[i] > 0) begin
            if (d[i] >= 64'sd2147483648) huge = 1'b1;
            else sum = sum + d[i] * d[i];
         end
      end
      dmax = d[0];
      if (d[1] > dmax) dmax = d[1];
      if (d[2] > dmax) dmax = d[2];
      if (huge) begin
         res = longint'(tbd_pkg::OUT_MAX);
      end else begin
         res = longint'(root_floor(sum)) + ((dmax < 0) ? dmax : 0);
         if (res > longint'(tbd_pkg::OUT_MAX)) res = longint'(tbd_pkg::OUT_MAX);
      end
      return res[31:0];
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         if (pending_points.size() > 0 && $urandom_range(99) >= idle_pct) begin
            point_type p;
            p = pending_points.pop_front();
            start     <= 1'b1;
            req_pos_x <= p.px;
            req_pos_y <= p.py;
            req_pos_z <= p.pz;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // prediction at request accept, checking at response strobe
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            expected_dist.push_back(box_distance({req_pos_x, req_pos_y, req_pos_z},
                                                 box_half));
         if (rsp_valid) begin
            if (expected_dist.size() == 0) begin
               errors++;
               $display("%0t: unexpected response distance=%0d", $time, rsp_distance);
            end else begin
               logic signed [31:0] want;
               want = expected_dist.pop_front();
               if (rsp_distance !== want) begin
                  errors++;
                  $display("%0t: distance mismatch expected=%0d actual=%0d",
                           $time, want, rsp_distance);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || psel) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("testbench: errors");
            $finish;
         end
      end
   end

   task automatic csr_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0; penable <= 1'b0;
      if (addr == ADDR_HALF_EDGE) box_half = data[30:0];
   endtask

   task automatic csr_check;
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= ADDR_HALF_EDGE;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0; penable <= 1'b0;
      if (prdata[30:0] !== box_half) begin
         errors++;
         $display("%0t: half_edge readback expected=%0d actual=%0d",
                  $time, box_half, prdata[30:0]);
      end
   endtask

   function automatic logic signed [31:0] near_coord(input logic [30:0] half);
      logic [31:0] span;
      span = (half > 31'h1FFF_FFFF) ? 32'h7FFF_FFFF : {half[29:0], 2'b00} + 32'h0003_0000;
      return $signed($urandom_range(span)) - $signed(span >> 1);
   endfunction

   task automatic add_random(input int n);
      point_type p;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(3))
            0: p = {$urandom, $urandom, $urandom};
            1: p = {near_coord(box_half), near_coord(box_half), near_coord(box_half)};
            2: p = {near_coord(box_half), $urandom, near_coord(box_half)};
            default: p = {$urandom >> $urandom_range(31), near_coord(box_half),
                          -($urandom >> $urandom_range(31))};
         endcase
         pending_points.push_back(p);
      end
   endtask

   task automatic drain;
      while (pending_points.size() != 0 || start || expected_dist.size() != 0)
         @(posedge clock);
   endtask

   localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] SMIN = 32'sh8000_0000;

   initial begin
      reset = 1'b1;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      box_half = 31'(1 << tbd_pkg::FRAC_BITS_DEFAULT);
      idle_pct = 0; errors = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      csr_check;

      // directed: origin, extremes, quadrants, inside, huge
      pending_points.push_back({32'sd0, 32'sd0, 32'sd0});
      pending_points.push_back({SMAX, SMAX, SMAX});
      pending_points.push_back({SMIN, SMIN, SMIN});
      pending_points.push_back({SMAX, 32'sd0, SMIN});
      pending_points.push_back({SMIN, SMAX, SMAX});
      pending_points.push_back({32'sh0000_8000, 32'sh0000_4000, -32'sh0000_8000});
      pending_points.push_back({32'sh0000_0001, -32'sh0000_0001, 32'sh0000_0000});
      pending_points.push_back({32'sd0, 32'sh0000_FFFF, 32'sd0});
      pending_points.push_back({32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000});
      pending_points.push_back({32'sh0003_0000, 32'sh0000_8637, 32'sh0002_0000});
      pending_points.push_back({32'sh0003_0000, 32'sh0001_0C6F, 32'sh0002_0000});
      pending_points.push_back({32'sh0003_0000, 32'sh0001_92A7, -32'sh0002_0000});
      pending_points.push_back({-32'sh0003_0000, -32'sh0000_8637, 32'sh0002_0000});
      pending_points.push_back({32'sh4000_0000, 32'sh0000_2000, 32'sh4000_0000});
      pending_points.push_back({32'sd0, SMAX, 32'sd0});
      pending_points.push_back({32'sd0, SMIN, 32'sd0});
      pending_points.push_back({-32'sh0000_4000, 32'sh0000_C000, 32'sh0000_2000});
      pending_points.push_back({32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA});
      pending_points.push_back({32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555});
      add_random(300);
      drain;

      idle_pct = 79;
      csr_write(ADDR_HALF_EDGE, 32'd0);
      csr_check;
      pending_points.push_back({32'sd0, 32'sd0, 32'sd0});
      pending_points.push_back({SMIN, SMIN, SMIN});
      add_random(300);
      drain;

      idle_pct = 0;
      csr_write(ADDR_HALF_EDGE, 32'hFFFF_FFFF);
      csr_write(ADDR_UNUSED, 32'h0000_1234);
      csr_check;
      pending_points.push_back({SMAX, SMAX, SMAX});
      pending_points.push_back({SMIN, SMIN, SMIN});
      add_random(300);
      drain;

      idle_pct = 9;
      csr_write(ADDR_HALF_EDGE, 32'h0000_0001);
      csr_check;
      add_random(300);
      drain;

      idle_pct = 0;
      csr_write(ADDR_HALF_EDGE, $urandom);
      csr_check;
      add_random(150);
      drain;

      idle_pct = 79;
      csr_write(ADDR_HALF_EDGE, 32'h0004_8000);
      csr_check;
      add_random(150);
      drain;

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end
endmodule

// ===== files.f =====
src/tbd_pkg.sv
src/tbd_horner_cell.sv
src/tbd_sqrt_cell.sv
src/twisted_box_distance.sv
verif/testbench.sv
